FILE: hw/rtl/touch_frame_deframer_top_defines.svh
// Assertion macros shared by the touch frame deframer RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef TOUCH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define TOUCH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TFD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tfd_pkg.sv
// Types and constants of the touch frame deframer.
// Used by the interfaces, the frame evaluator and the top level; no dependencies.
`default_nettype none

package tfd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned SUM_W   = 11;

    localparam logic [POS_W-1:0] POS_HUNT  = 3'd0;
    localparam logic [POS_W-1:0] POS_CMD   = 3'd1;
    localparam logic [POS_W-1:0] POS_XH    = 3'd2;
    localparam logic [POS_W-1:0] POS_XL    = 3'd3;
    localparam logic [POS_W-1:0] POS_YH    = 3'd4;
    localparam logic [POS_W-1:0] POS_YL    = 3'd5;
    localparam logic [POS_W-1:0] POS_FLAG  = 3'd6;
    localparam logic [POS_W-1:0] POS_CHECK = 3'd7;

    localparam logic [BYTE_W-1:0] CMD_SAMPLE  = 8'd1;
    localparam logic [BYTE_W-1:0] CMD_COMPUTE = 8'd2;

    localparam int unsigned FLAG_Y_HIGH = 3;
    localparam int unsigned FLAG_Y_LOW  = 2;
    localparam int unsigned FLAG_X_HIGH = 1;
    localparam int unsigned FLAG_X_LOW  = 0;

    localparam logic [BYTE_W:0]   SUM_MODULUS  = 9'd255;
    localparam logic [WORD_W-1:0] INDEX_RESET  = 16'd159;

    localparam logic KIND_SAMPLE  = 1'b0;
    localparam logic KIND_COMPUTE = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] x_low;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] y_low;
        logic [BYTE_W-1:0] flag;
    } t_frame;

    typedef struct packed {
        logic              hit;
        logic              event_kind;
        logic [WORD_W-1:0] sample_index;
        logic [WORD_W-1:0] sample_value;
    } t_result;

endpackage

`default_nettype wire

FILE: hw/rtl/tfd_byte_if.sv
// Channel that carries received serial bytes into the deframer.
// Depends on tfd_pkg for the byte width.
`default_nettype none

interface tfd_byte_if;
    logic                            valid;
    logic                            ready;
    logic [tfd_pkg::BYTE_W-1:0]      rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tfd_event_if.sv
// Channel that carries sample and compute events out of the deframer.
// Depends on tfd_pkg for the word width.
`default_nettype none

interface tfd_event_if;
    logic                            valid;
    logic                            ready;
    logic                            event_kind;
    logic [tfd_pkg::WORD_W-1:0]      sample_index;
    logic [tfd_pkg::WORD_W-1:0]      sample_value;

    modport source (output valid, output event_kind, output sample_index,
                    output sample_value, input ready);
    modport sink (input valid, input event_kind, input sample_index,
                  input sample_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tfd_frame_eval.sv
// Forms the event; a sample frame is checked against its checksum byte and i_limit.
// Depends on tfd_pkg for the frame and result types.
`default_nettype none

module tfd_frame_eval (
    input  var tfd_pkg::t_frame                i_frame,
    input  var logic [tfd_pkg::SUM_W-1:0]      i_sum,
    input  var logic [tfd_pkg::BYTE_W-1:0]     i_check,
    input  var logic [tfd_pkg::WORD_W-1:0]     i_limit,
    output tfd_pkg::t_result                   o_result
);

    logic [tfd_pkg::BYTE_W:0]   fold;
    logic [tfd_pkg::BYTE_W:0]   residue;
    logic                       sum_ok;
    logic [tfd_pkg::BYTE_W-1:0] x_high;
    logic [tfd_pkg::BYTE_W-1:0] x_low;
    logic [tfd_pkg::BYTE_W-1:0] y_high;
    logic [tfd_pkg::BYTE_W-1:0] y_low;
    logic [tfd_pkg::WORD_W-1:0] x;
    logic [tfd_pkg::WORD_W-1:0] y;

    // Since 256 is congruent to 1 modulo 255, the high bits fold onto the low byte.
    always_comb begin
        fold = {6'd0, i_sum[tfd_pkg::SUM_W-1:tfd_pkg::BYTE_W]}
             + {1'b0, i_sum[tfd_pkg::BYTE_W-1:0]};
        if (fold >= tfd_pkg::SUM_MODULUS) begin
            residue = fold - tfd_pkg::SUM_MODULUS;
        end else begin
            residue = fold;
        end
        sum_ok = (residue == {1'b0, i_check});
    end

    always_comb begin
        x_high = i_frame.flag[tfd_pkg::FLAG_X_HIGH] ? '0 : i_frame.x_high;
        x_low  = i_frame.flag[tfd_pkg::FLAG_X_LOW]  ? '0 : i_frame.x_low;
        y_high = i_frame.flag[tfd_pkg::FLAG_Y_HIGH] ? '0 : i_frame.y_high;
        y_low  = i_frame.flag[tfd_pkg::FLAG_Y_LOW]  ? '0 : i_frame.y_low;
        x = {x_high, x_low};
        y = {y_high, y_low};
    end

    always_comb begin
        o_result = '0;
        priority if (i_frame.cmd == tfd_pkg::CMD_COMPUTE) begin
            o_result.hit        = 1'b1;
            o_result.event_kind = tfd_pkg::KIND_COMPUTE;
        end else if (i_frame.cmd == tfd_pkg::CMD_SAMPLE) begin
            o_result.hit          = sum_ok && (x <= i_limit);
            o_result.event_kind   = tfd_pkg::KIND_SAMPLE;
            o_result.sample_index = x;
            o_result.sample_value = y;
        end else begin
            o_result.hit = 1'b0;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/touch_frame_deframer_top.sv
// Touch frame deframer top level: byte input channel, event output channel,
// limit register. Depends on tfd_pkg, tfd_byte_if, tfd_event_if and tfd_frame_eval.
//
// Usage:
// Bytes arrive on i_rx, one transfer per byte, and events leave on o_ev.
// While hunting, a zero byte opens an eight-byte frame; the next six bytes are
// taken as data. The frame's last byte is its checksum, and the event
// it causes is loaded into the output register at the edge that accepts that
// byte, so it is offered on o_ev in the next cycle.
// Throughput is one byte per cycle, set by the position counter and the single
// output register. When the receiver stalls, bytes inside a frame are still
// taken; only a checksum byte waits until the pending event has been
// transferred. Reset returns the block to hunting, empties the output register
// and sets the index limit to 159; i_cfg_we writes a new limit from i_cfg_wdata
// and must only be used while the block is idle.
`default_nettype none
`include "touch_frame_deframer_top_defines.svh"

module touch_frame_deframer_top (
    input  var logic                           i_clk,
    input  var logic                           i_rst_n,
    input  var logic                           i_cfg_we,
    input  var logic [tfd_pkg::WORD_W-1:0]     i_cfg_wdata,
    tfd_byte_if.sink                           i_rx,
    tfd_event_if.source                        o_ev
);

    logic [tfd_pkg::POS_W-1:0]  r_pos;
    logic [tfd_pkg::WORD_W-1:0] r_limit;
    logic                       r_out_valid;
    tfd_pkg::t_result           r_ev;
    tfd_pkg::t_frame            r_frame;
    logic [tfd_pkg::SUM_W-1:0]  r_sum;
    tfd_pkg::t_result           n_ev;
    logic                       in_acc;
    logic                       at_check;

    assign at_check   = (r_pos == tfd_pkg::POS_CHECK);
    assign i_rx.ready = !at_check || !r_out_valid || o_ev.ready;
    assign in_acc     = i_rx.valid && i_rx.ready;

    tfd_frame_eval u_eval (
        .i_frame  (r_frame),
        .i_sum    (r_sum),
        .i_check  (i_rx.rx_byte),
        .i_limit  (r_limit),
        .o_result (n_ev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= tfd_pkg::POS_HUNT;
            r_out_valid <= 1'b0;
            r_limit     <= tfd_pkg::INDEX_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (in_acc && at_check) begin
                r_out_valid <= n_ev.hit;
            end else if (o_ev.ready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                unique case (r_pos)
                    tfd_pkg::POS_HUNT: begin
                        if (i_rx.rx_byte == '0) begin
                            r_pos <= tfd_pkg::POS_CMD;
                        end
                    end
                    tfd_pkg::POS_CHECK: begin
                        r_pos <= tfd_pkg::POS_HUNT;
                    end
                    default: begin
                        r_pos <= r_pos + 3'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            unique case (r_pos)
                tfd_pkg::POS_CMD: begin
                    r_frame.cmd <= i_rx.rx_byte;
                    r_sum       <= {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_XH: begin
                    r_frame.x_high <= i_rx.rx_byte;
                    r_sum          <= r_sum + {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_XL: begin
                    r_frame.x_low <= i_rx.rx_byte;
                    r_sum         <= r_sum + {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_YH: begin
                    r_frame.y_high <= i_rx.rx_byte;
                    r_sum          <= r_sum + {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_YL: begin
                    r_frame.y_low <= i_rx.rx_byte;
                    r_sum         <= r_sum + {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_FLAG: begin
                    r_frame.flag <= i_rx.rx_byte;
                    r_sum        <= r_sum + {3'd0, i_rx.rx_byte};
                end
                tfd_pkg::POS_CHECK: begin
                    r_ev <= n_ev;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_ev.valid        = r_out_valid;
    assign o_ev.event_kind   = r_ev.event_kind;
    assign o_ev.sample_index = r_ev.sample_index;
    assign o_ev.sample_value = r_ev.sample_value;

    `TFD_ASSERT_SAME(a_compute_zero, i_clk, i_rst_n,
        r_out_valid && (r_ev.event_kind == tfd_pkg::KIND_COMPUTE),
        (r_ev.sample_index == '0) && (r_ev.sample_value == '0),
        "Compute event carries a nonzero index or value.")
    `TFD_ASSERT_SAME(a_index_limit, i_clk, i_rst_n,
        r_out_valid && (r_ev.event_kind == tfd_pkg::KIND_SAMPLE) && !$past(i_cfg_we),
        r_ev.sample_index <= r_limit,
        "Sample event index lies above the configured limit.")
    `TFD_ASSERT_NEXT(a_data_no_event, i_clk, i_rst_n,
        in_acc && !at_check && (!r_out_valid || o_ev.ready),
        !r_out_valid,
        "A byte other than a checksum produced an event.")
    `TFD_ASSERT_NEXT(a_hunt_stays, i_clk, i_rst_n,
        in_acc && (r_pos == tfd_pkg::POS_HUNT) && (i_rx.rx_byte != '0),
        r_pos == tfd_pkg::POS_HUNT,
        "A nonzero byte opened a frame while hunting.")

endmodule

`default_nettype wire
